// ===== rtl/core/madl_pkg.sv =====
// ----------------------------------------------------------------------------
// madl_pkg: shared definitions for the address allow/deny list filter
// Field widths, operation codes, sequencer states and stream widths.
// ----------------------------------------------------------------------------
package madl_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int OP_W     = 2;
    localparam int ADDR_W   = 48;
    localparam int TYPE_W   = 8;
    localparam int MASK_W   = 2;
    localparam int ENTRY_W  = 5;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_ALLOW = 2'd0,
        OP_ADD_DENY  = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_CHECK     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_LAST = 2'd2,
        ST_DONE = 2'd3
    } state_t;

endpackage

// ===== rtl/core/madl_ram.sv =====
// ----------------------------------------------------------------------------
// madl_ram: generic single-clock ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module madl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/mac_allow_deny_list_filter.sv =====
// ----------------------------------------------------------------------------
// mac_allow_deny_list_filter: device address allow/deny list filter
// Keeps a list of 48-bit addresses with an allow or deny mode and checks
// reported devices against it, one stored entry compared per cycle.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one item per command; s_tuser carries the opcode (add to
//   allow list, add to deny list, clear, check), s_tdata the address and
//   the address type. m_ channel: one result item per command with the
//   accept flag and the entry count after the command.
//   cfg channel: writes the 2-bit address type mask, always ready; write it
//   only while no command is in flight.
// sequence
//   add and clear: the accepting edge moves the sequencer to the done step, which
//   loads the output register and returns to idle
//   check: idle, then the scan step once per stored entry, the last step for the
//   final compare, then done; a check on an empty list goes straight to done; the scan
//   reads the address ram once per entry through its single read port
//   one command at a time: s_tready is high only while the sequencer idles
// reset
//   aresetn low (synchronous) empties the list, selects allow mode, clears
//   the mask and drops any pending result; ram contents are left as is
// stall
//   a result waits in the output register while m_tready is low; the next
//   command is still taken and its result held back until the register frees
// ----------------------------------------------------------------------------
module mac_allow_deny_list_filter #(
    parameter int TABLE_DEPTH = madl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // command stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [madl_pkg::S_TDATA_W-1:0]   s_tdata,   // device_addr[47:0], addr_type[55:48]
    input  logic [madl_pkg::OP_W-1:0]        s_tuser,   // opcode[1:0]
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [madl_pkg::M_TDATA_W-1:0]   m_tdata,   // accept[0], entry_count[5:1], zero[7:6]
    // configuration write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [madl_pkg::MASK_W-1:0]      cfg_data   // addr_type_mask[1:0]
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W  = madl_pkg::ADDR_W;
    localparam int TYPE_W  = madl_pkg::TYPE_W;
    localparam int MASK_W  = madl_pkg::MASK_W;
    localparam int ENTRY_W = madl_pkg::ENTRY_W;

    // sequencer and command registers
    madl_pkg::state_t  state_reg, state_next;
    madl_pkg::opcode_t op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [TYPE_W-1:0] type_reg, type_next;

    // list state
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              deny_reg, deny_next;
    logic [MASK_W-1:0] mask_reg;

    // scan state
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;   // ram read data is valid to compare
    logic              hit_reg, hit_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic               m_accept_reg, m_accept_next;
    logic [ENTRY_W-1:0] m_count_reg, m_count_next;

    // ram ports
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [ADDR_W-1:0] rd_data;

    logic match;
    logic pass;

    madl_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[ADDR_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready  = (state_reg == madl_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(madl_pkg::M_TDATA_W - ENTRY_W - 1){1'b0}}, m_count_reg, m_accept_reg};

    // the one comparator, fed by the ram read port during the scan
    assign match = pend_reg && (rd_data == addr_reg);

    // empty list passes in either mode, otherwise membership xor deny
    assign pass = (count_reg == '0) ? 1'b1 : (hit_reg ^ deny_reg);

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        type_next     = type_reg;
        count_next    = count_reg;
        deny_next     = deny_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        hit_next      = hit_reg;
        m_valid_next  = m_valid_reg;
        m_accept_next = m_accept_reg;
        m_count_next  = m_count_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[IDX_W-1:0];
        rd_en         = 1'b0;
        rd_addr       = idx_reg;

        // result taken downstream
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            madl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    op_next   = madl_pkg::opcode_t'(s_tuser);
                    addr_next = s_tdata[ADDR_W-1:0];
                    type_next = s_tdata[ADDR_W +: TYPE_W];
                    hit_next  = 1'b0;
                    pend_next = 1'b0;
                    idx_next  = '0;
                    case (madl_pkg::opcode_t'(s_tuser))
                        madl_pkg::OP_ADD_ALLOW, madl_pkg::OP_ADD_DENY: begin
                            deny_next = (madl_pkg::opcode_t'(s_tuser) == madl_pkg::OP_ADD_DENY);
                            // full list: mode still changes, address dropped
                            if (count_reg < CNT_W'(TABLE_DEPTH)) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            state_next = madl_pkg::ST_DONE;
                        end
                        madl_pkg::OP_CLEAR: begin
                            count_next = '0;
                            state_next = madl_pkg::ST_DONE;
                        end
                        madl_pkg::OP_CHECK: begin
                            if (count_reg == '0) begin
                                state_next = madl_pkg::ST_DONE;
                            end else begin
                                state_next = madl_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = madl_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            madl_pkg::ST_SCAN: begin
                // read entry idx, compare the one read last cycle
                rd_en     = 1'b1;
                pend_next = 1'b1;
                hit_next  = hit_reg | match;
                if (CNT_W'(idx_reg) + CNT_W'(1) == count_reg) begin
                    state_next = madl_pkg::ST_LAST;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            madl_pkg::ST_LAST: begin
                // compare the final entry
                hit_next   = hit_reg | match;
                pend_next  = 1'b0;
                state_next = madl_pkg::ST_DONE;
            end
            madl_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_accept_next = (op_reg == madl_pkg::OP_CHECK) && pass &&
                                    ((type_reg[MASK_W-1:0] & mask_reg) == '0);
                    m_count_next  = ENTRY_W'(count_reg);
                    state_next    = madl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = madl_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= madl_pkg::ST_IDLE;
            count_reg   <= '0;
            deny_reg    <= 1'b0;
            mask_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            deny_reg    <= deny_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                mask_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        type_reg     <= type_next;
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        m_accept_reg <= m_accept_next;
        m_count_reg  <= m_count_next;
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new item taken while the previous one is in work");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(state_reg == madl_pkg::ST_DONE))
        else $error("result loaded outside the done step");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the address allow/deny list filter
// Streams add, clear and check commands into the filter. A local model
// tracks the address list, the list mode and the type mask, and every
// result item is compared against it in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIST_DEPTH   = madl_pkg::TABLE_DEPTH_DEF;
    localparam int ADDR_W       = madl_pkg::ADDR_W;
    localparam int TYPE_W       = madl_pkg::TYPE_W;
    localparam int MASK_W       = madl_pkg::MASK_W;
    localparam int ENTRY_W      = madl_pkg::ENTRY_W;
    localparam int OP_W         = madl_pkg::OP_W;
    localparam int S_TDATA_W    = madl_pkg::S_TDATA_W;
    localparam int M_TDATA_W    = madl_pkg::M_TDATA_W;
    localparam int DRAIN_CYCLES = 40;      // settle time once all results are in
    localparam int WATCHDOG_MAX = 3000;    // well above the receiver hold-off
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
    localparam int HOLD_AFTER   = 40;      // results seen before the hold-off starts
    localparam int RANDOM_CHUNK = 195;     // random commands per mask setting
    localparam int POOL_SIZE    = 24;      // addresses reused within one chunk

    // one command item as it travels on the s_ stream
    typedef struct {
        madl_pkg::opcode_t op;
        logic [ADDR_W-1:0] addr;
        logic [TYPE_W-1:0] atype;
    } filter_cmd_t;

    // one result item: accept flag and entry count after the command
    typedef struct packed {
        logic               accept;
        logic [ENTRY_W-1:0] count;
    } filter_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // device_addr[47:0], addr_type[55:48]
    logic [OP_W-1:0]      s_tuser   = '0;   // opcode[1:0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // accept[0], entry_count[5:1], zero[7:6]
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [MASK_W-1:0]    cfg_data  = '0;   // addr_type_mask[1:0]

    // local copy of the filter state
    logic [ADDR_W-1:0] list_addr [LIST_DEPTH];
    int                list_count = 0;
    logic              list_deny  = 1'b0;
    logic [MASK_W-1:0] type_mask  = '0;

    filter_cmd_t    command_q [$];   // commands waiting to be sent
    filter_result_t verdict_q [$];   // results owed by the filter, oldest first

    int   fault_count  = 0;
    int   results_seen = 0;
    int   quiet_cycles = 0;
    int   s_idle_pct   = 8;
    int   m_idle_pct   = 77;
    int   hold_left    = 0;
    bit   held_once    = 1'b0;
    bit   cmd_taken    = 1'b0;
    bit   pref_deny    = 1'b0;
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    mac_allow_deny_list_filter #(
        .TABLE_DEPTH(LIST_DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // 12 ns clock
    always #6 aclk = ~aclk;

    // applies one command to the local state and returns the result it owes
    function automatic filter_result_t filter_apply(madl_pkg::opcode_t op,
                                                    logic [ADDR_W-1:0] addr,
                                                    logic [TYPE_W-1:0] atype);
        filter_result_t res;
        logic           hit;
        logic           pass;
        res.accept = 1'b0;
        case (op)
            madl_pkg::OP_ADD_ALLOW, madl_pkg::OP_ADD_DENY: begin
                // mode follows the latest add, even when the list is full
                list_deny = (op == madl_pkg::OP_ADD_DENY);
                if (list_count < LIST_DEPTH) begin
                    list_addr[list_count] = addr;
                    list_count++;
                end
            end
            madl_pkg::OP_CLEAR: begin
                list_count = 0;
            end
            default: begin
                hit = 1'b0;
                for (int i = 0; i < list_count; i++)
                    if (list_addr[i] == addr)
                        hit = 1'b1;
                // empty list passes in either mode
                pass = (list_count == 0) ? 1'b1 : (hit ^ list_deny);
                res.accept = pass && ((atype[MASK_W-1:0] & type_mask) == '0);
            end
        endcase
        res.count = ENTRY_W'(list_count);
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic queue_cmd(input madl_pkg::opcode_t op, input logic [ADDR_W-1:0] addr,
                             input logic [TYPE_W-1:0] atype);
        filter_cmd_t c;
        c.op    = op;
        c.addr  = addr;
        c.atype = atype;
        command_q.push_back(c);
    endtask

    // waits until every command is sent and answered, then lets the block settle
    task automatic wait_quiet();
        do @(negedge aclk); while (command_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] mask);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mask;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // random commands drawn mostly from a small address pool, so checks hit
    // listed addresses and the list fills up between the rare clears
    task automatic run_random(input int n);
        filter_cmd_t c;
        int          r;
        bit          deny;
        @(posedge aclk);
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++)
            addr_pool[k] = rand_addr();
        for (int k = 0; k < n; k++) begin
            r       = $urandom_range(0, 99);
            c.atype = 8'($urandom);
            c.addr  = ($urandom_range(0, 99) < 80) ? addr_pool[$urandom_range(0, POOL_SIZE-1)]
                                                   : rand_addr();
            if (r < 2) begin
                c.op      = madl_pkg::OP_CLEAR;
                pref_deny = 1'($urandom_range(0, 1));
            end else if (r < 40) begin
                // most adds keep the current mode, a few flip it
                deny = ($urandom_range(0, 99) < 85) ? pref_deny : !pref_deny;
                c.op = deny ? madl_pkg::OP_ADD_DENY : madl_pkg::OP_ADD_ALLOW;
            end else begin
                c.op = madl_pkg::OP_CHECK;
                // half the checks carry types that the mask cannot reject
                if ($urandom_range(0, 1))
                    c.atype[MASK_W-1:0] = '0;
            end
            command_q.push_back(c);
        end
        wait_quiet();
    endtask

    // command driver: holds an item until taken, idles at random between items
    always @(negedge aclk) begin
        if (s_tvalid && !cmd_taken) begin
            // item still on offer
        end else if (command_q.size() != 0 && $urandom_range(0, 99) >= s_idle_pct) begin
            s_tvalid <= 1'b1;
            s_tuser  <= command_q[0].op;
            s_tdata  <= {command_q[0].atype, command_q[0].addr};
        end else begin
            s_tvalid <= 1'b0;
        end
        cmd_taken = 1'b0;
    end

    // result receiver: random stalls plus one long hold-off while commands keep coming
    always @(negedge aclk) begin
        if (!held_once && results_seen >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
        end
    end

    // command monitor: each accepted item is run through the local model
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            verdict_q.push_back(filter_apply(madl_pkg::opcode_t'(s_tuser),
                                             s_tdata[ADDR_W-1:0],
                                             s_tdata[ADDR_W +: TYPE_W]));
            void'(command_q.pop_front());
            cmd_taken = 1'b1;
        end
        if (aresetn && cfg_valid && cfg_ready)
            type_mask = cfg_data;
    end

    // result monitor and watchdog
    always @(posedge aclk) begin
        filter_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result item, expected none, got accept %0d count %0d",
                         $time, m_tdata[0], m_tdata[5:1]);
                fault_count++;
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[0] !== want.accept) begin
                    $display("%0t: accept mismatch, expected %0d, got %0d",
                             $time, want.accept, m_tdata[0]);
                    fault_count++;
                end
                if (m_tdata[5:1] !== want.count) begin
                    $display("%0t: entry_count mismatch, expected %0d, got %0d",
                             $time, want.count, m_tdata[5:1]);
                    fault_count++;
                end
            end
        end
        // any handshake on any channel counts as progress
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("mac_allow_deny_list_filter verification failed");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, mask still at its reset value of zero
        queue_cmd(madl_pkg::OP_CHECK, '1, 8'hFF);                   // empty list passes
        queue_cmd(madl_pkg::OP_ADD_ALLOW, '0, 8'h00);
        queue_cmd(madl_pkg::OP_ADD_ALLOW, '1, 8'hFF);
        queue_cmd(madl_pkg::OP_CHECK, '0, 8'h00);                   // listed, allow mode
        queue_cmd(madl_pkg::OP_CHECK, 48'h0000_0000_0001, 8'hFF);   // not listed, allow mode
        queue_cmd(madl_pkg::OP_ADD_DENY, 48'h5555_5555_5555, 8'h00); // switches to deny mode
        queue_cmd(madl_pkg::OP_CHECK, '0, 8'h00);                   // listed, deny mode
        queue_cmd(madl_pkg::OP_CHECK, 48'hAAAA_AAAA_AAAA, 8'hAA);   // not listed, deny mode
        for (int k = 0; k < LIST_DEPTH - 3; k++)
            queue_cmd(madl_pkg::OP_ADD_DENY, 48'h0000_1000_0000 + k, 8'h00);
        // list full: address dropped but the mode still flips to allow
        queue_cmd(madl_pkg::OP_ADD_ALLOW, 48'h8000_0000_0001, 8'h00);
        queue_cmd(madl_pkg::OP_CHECK, 48'h8000_0000_0001, 8'h00);
        queue_cmd(madl_pkg::OP_CHECK, 48'h0000_1000_0000 + LIST_DEPTH - 4, 8'h55);
        queue_cmd(madl_pkg::OP_CLEAR, 48'h1234_5678_9ABC, 8'hFF);
        queue_cmd(madl_pkg::OP_CHECK, 48'h5555_5555_5555, 8'h01);   // empty again after clear
        wait_quiet();

        // sender mostly busy, receiver mostly stalled
        write_mask(2'd3);
        run_random(RANDOM_CHUNK);
        write_mask(2'd1);
        run_random(RANDOM_CHUNK);

        // roles swapped
        s_idle_pct = 77;
        m_idle_pct = 8;
        write_mask(2'd2);
        run_random(RANDOM_CHUNK);

        // full rate on both sides
        s_idle_pct = 0;
        m_idle_pct = 0;
        write_mask(2'd0);
        run_random(RANDOM_CHUNK);

        if (fault_count == 0)
            $display("mac_allow_deny_list_filter verification clean");
        else
            $display("mac_allow_deny_list_filter verification failed");
        $finish;
    end

endmodule
